@@ hdl/bbd_pkg.sv @@
// Shared types, constants and the CFA site lookup for the Bayer demosaic block.
package bbd_pkg;

    // Field widths
    localparam int RAW_W   = 10;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;
    localparam int DIM_W   = 15;   // holds any clipped frame width up to 16384
    localparam int LINE_W  = 2 * PIX_W;

    // Frame limits
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int ROW_LIMIT     = 4096;

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);
    localparam logic [1:0]       CFA_PATTERN_RST  = 2'd3;

    // Result group queue
    localparam int GRP_DEPTH  = 4;
    localparam int PTR_W      = $clog2(GRP_DEPTH);
    localparam int CNT_W      = $clog2(GRP_DEPTH + 1);
    localparam int RESULT_CAP = 4;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CFA_PATTERN  = 3'd2,
        REG_COLUMN_PHASE = 3'd3,
        REG_ROW_PHASE    = 3'd4,
        REG_BLACK_LEVEL  = 3'd5
    } t_reg_idx;

    // Color at the center of the 3x3 window
    typedef enum logic [1:0] {
        SITE_R      = 2'd0,
        SITE_G_RROW = 2'd1,
        SITE_G_BROW = 2'd2,
        SITE_B      = 2'd3
    } t_site;

    // Rows: GBRG, GRBG, BGGR, RGGB; columns: {row parity, column parity}
    localparam t_site SITE_TABLE [4][4] = '{
        '{SITE_G_BROW, SITE_B,      SITE_R,      SITE_G_RROW},
        '{SITE_G_RROW, SITE_R,      SITE_B,      SITE_G_BROW},
        '{SITE_B,      SITE_G_BROW, SITE_G_RROW, SITE_R     },
        '{SITE_R,      SITE_G_RROW, SITE_G_BROW, SITE_B     }
    };

    // Active configuration, widths already clipped
    typedef struct packed {
        logic [DIM_W-1:0] frame_w;
        logic [CFG_W-1:0] frame_h;
        logic [1:0]       cfa_pattern;
        logic             column_phase;
        logic             row_phase;
        logic [PIX_W-1:0] black_level;
    } t_cfg;

    typedef logic [8:0][PIX_W-1:0] t_win;

    // Position of the newest source pixel in the window, below and right of the center
    typedef struct packed {
        logic               valid;
        logic [DIM_W-1:0]   col;
        logic [COORD_W-1:0] row;
    } t_pos;

    // One interior pixel with its border copies
    typedef struct packed {
        logic [PIX_W-1:0]        red;
        logic [PIX_W-1:0]        green;
        logic [PIX_W-1:0]        blue;
        logic [2:0][COORD_W-1:0] rows;
        logic [1:0]              row_cnt;
        logic [2:0][COORD_W-1:0] cols;
        logic [1:0]              col_cnt;
        logic                    done;
    } t_group;

endpackage

@@ hdl/bayer_bilinear_demosaic.sv @@
// Top level of the bilinear Bayer demosaic block.
// Throughput: one input word per cycle unless o_stall is high; a group with border
// copies drains at one word per cycle unless i_stall, up to four words, and the
// four-entry group queue then holds off input.
// Line buffers sit in one 16-bit RAM with one read and one write per cycle.
// Reset clears counters, pipeline valids and queue pointers; line buffers are not cleared.
module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [RAW_W-1:0]      i_raw_sample,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_red,
    output logic [PIX_W-1:0]      o_green,
    output logic [PIX_W-1:0]      o_blue,
    output logic [COORD_W-1:0]    o_pixel_column,
    output logic [COORD_W-1:0]    o_pixel_row,
    output logic                  o_last_of_run,
    output logic                  o_frame_done,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg             cfg;
    t_win             win;
    t_pos             pos;
    t_group           group;
    logic             push;
    logic [1:0]       pend;
    logic [CNT_W-1:0] emit_count;
    logic             accept;

    // Hold input while queued plus in-flight groups could fill the queue
    assign o_stall = ((CNT_W+1)'(emit_count) + (CNT_W+1)'(pend)) >= (CNT_W+1)'(GRP_DEPTH);
    assign accept  = i_valid && !o_stall;

    bbd_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbd_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (accept),
        .i_raw_sample  (i_raw_sample),
        .i_frame_start (i_frame_start),
        .o_win         (win),
        .o_pos         (pos),
        .o_pend        (pend)
    );

    bbd_interp u_interp (
        .i_cfg   (cfg),
        .i_win   (win),
        .i_pos   (pos),
        .o_push  (push),
        .o_group (group)
    );

    bbd_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_group        (group),
        .i_stall        (i_stall),
        .o_count        (emit_count),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_count == CNT_W'(GRP_DEPTH)) |-> o_stall)
        else $error("input open while group queue full");

endmodule

@@ hdl/bbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, read-first registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/bbd_cfg.sv @@
// APB configuration registers of the Bayer demosaic block.
module bbd_cfg
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [1:0]       r_cfa_pattern;
    logic             r_column_phase;
    logic             r_row_phase;
    logic [PIX_W-1:0] r_black_level;
    logic             wr_fire;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_cfa_pattern  <= CFA_PATTERN_RST;
            r_column_phase <= 1'b0;
            r_row_phase    <= 1'b0;
            r_black_level  <= '0;
        end else if (wr_fire) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
                REG_CFA_PATTERN:  r_cfa_pattern  <= pwdata[1:0];
                REG_COLUMN_PHASE: r_column_phase <= pwdata[0];
                REG_ROW_PHASE:    r_row_phase    <= pwdata[0];
                REG_BLACK_LEVEL:  r_black_level  <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            REG_CFA_PATTERN:  prdata = APB_DATA_W'(r_cfa_pattern);
            REG_COLUMN_PHASE: prdata = APB_DATA_W'(r_column_phase);
            REG_ROW_PHASE:    prdata = APB_DATA_W'(r_row_phase);
            REG_BLACK_LEVEL:  prdata = APB_DATA_W'(r_black_level);
            default:          prdata = '0;
        endcase
    end

    // Clip width to the line buffer depth and height to the row range
    always_comb begin
        o_cfg.frame_w = (DIM_W'(r_frame_width) > DIM_W'(MAX_WIDTH))
                      ? DIM_W'(MAX_WIDTH) : DIM_W'(r_frame_width);
        o_cfg.frame_h = (r_frame_height > CFG_W'(ROW_LIMIT))
                      ? CFG_W'(ROW_LIMIT) : r_frame_height;
        o_cfg.cfa_pattern  = r_cfa_pattern;
        o_cfg.column_phase = r_column_phase;
        o_cfg.row_phase    = r_row_phase;
        o_cfg.black_level  = r_black_level;
    end

endmodule

@@ hdl/bbd_window.sv @@
// Position counters, line buffer read-modify-write and the 3x3 pixel window.
module bbd_window
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_accept,
    input  logic [RAW_W-1:0] i_raw_sample,
    input  logic             i_frame_start,
    output t_win             o_win,
    output t_pos             o_pos,
    output logic [1:0]       o_pend
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]      r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [CW-1:0]      cur_col;
    logic [COORD_W-1:0] cur_row;
    logic               col_wrap;
    logic               row_wrap;
    logic [PIX_W-1:0]   pix_red;
    logic [PIX_W-1:0]   pix_adj;

    logic               r_s1_v;
    logic [CW-1:0]      r_s1_col;
    logic [COORD_W-1:0] r_s1_row;
    logic [PIX_W-1:0]   r_s1_pix;
    logic               r_fwd_hit;
    logic [LINE_W-1:0]  r_fwd_data;
    logic [LINE_W-1:0]  ram_q;
    logic [LINE_W-1:0]  line_rd;
    logic [LINE_W-1:0]  line_wr;
    logic [PIX_W-1:0]   line_up;
    logic [PIX_W-1:0]   line_mid;

    t_win               r_win, n_win;
    logic               r_s2_v;
    logic [CW-1:0]      r_s2_col;
    logic [COORD_W-1:0] r_s2_row;

    // Restart the position on a frame start word
    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? '0 : r_row;

    // Advance column, wrap into the next row and frame
    always_comb begin
        col_wrap = (DIM_W'(cur_col) + DIM_W'(1)) >= i_cfg.frame_w;
        row_wrap = (CFG_W'(cur_row) + CFG_W'(1)) >= i_cfg.frame_h;
        n_col    = r_col;
        n_row    = r_row;
        if (i_accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : cur_row + COORD_W'(1);
            end else begin
                n_col = cur_col + CW'(1);
                n_row = cur_row;
            end
        end
    end

    // Reduce to 8 bits and subtract the black level, floor at zero
    assign pix_red = i_raw_sample[RAW_W-1:2];
    assign pix_adj = (pix_red > i_cfg.black_level) ? pix_red - i_cfg.black_level : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_s1_v    <= i_accept;
            r_s2_v    <= r_s1_v;
            r_fwd_hit <= r_s1_v && (r_s1_col == cur_col);
        end
    end

    // Capture the accepted word and the line write that coincides with its read
    always_ff @(posedge i_clk) begin
        r_s1_col   <= cur_col;
        r_s1_row   <= cur_row;
        r_s1_pix   <= pix_adj;
        r_fwd_data <= line_wr;
        r_s2_col   <= r_s1_col;
        r_s2_row   <= r_s1_row;
        r_win      <= n_win;
    end

    // Line buffers as one RAM: upper byte above, lower byte middle line
    bbd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_v),
        .i_wr_addr (r_s1_col),
        .i_wr_data (line_wr),
        .i_rd_addr (cur_col),
        .o_rd_data (ram_q)
    );

    // Forward a write that landed on the same edge as this read
    assign line_rd  = r_fwd_hit ? r_fwd_data : ram_q;
    assign line_up  = line_rd[LINE_W-1:PIX_W];
    assign line_mid = line_rd[PIX_W-1:0];
    assign line_wr  = {line_mid, r_s1_pix};

    // Shift the window left and load the new column
    always_comb begin
        n_win = r_win;
        if (r_s1_v) begin
            for (int i = 0; i < 3; i++) begin
                n_win[i*3]     = r_win[i*3+1];
                n_win[i*3 + 1] = r_win[i*3+2];
            end
            n_win[2] = line_up;
            n_win[5] = line_mid;
            n_win[8] = r_s1_pix;
        end
    end

    assign o_win       = r_win;
    assign o_pos.valid = r_s2_v;
    assign o_pos.col   = DIM_W'(r_s2_col);
    assign o_pos.row   = r_s2_row;
    assign o_pend      = {1'b0, r_s1_v} + {1'b0, r_s2_v};

    // Forwarded data only comes from a real write in the previous cycle
    a_fwd_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_fwd_hit) |-> $past(r_s1_v))
        else $error("line forward without a write");

endmodule

@@ hdl/bbd_interp.sv @@
// Bilinear interpolation and border copy list for one window position.
module bbd_interp
    import bbd_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_win   i_win,
    input  t_pos   i_pos,
    output logic   o_push,
    output t_group o_group
);

    logic [DIM_W-1:0]   w_m1, w_m2, xw;
    logic [CFG_W-1:0]   h_m1, h_m2, r_ext;
    logic [COORD_W-1:0] yw;
    logic               interior;
    logic               left, right, top, bottom;
    logic [1:0]         site_idx;
    t_site              site;
    logic [PIX_W+1:0]   hv_sum, dg_sum;
    logic [PIX_W:0]     hz_sum, vt_sum;
    logic [PIX_W-1:0]   hv, dg, hz, vt;
    logic [COORD_W-1:0] x12, w12, h12;

    // Geometry of the center pixel
    always_comb begin
        w_m1  = i_cfg.frame_w - DIM_W'(1);
        w_m2  = i_cfg.frame_w - DIM_W'(2);
        h_m1  = i_cfg.frame_h - CFG_W'(1);
        h_m2  = i_cfg.frame_h - CFG_W'(2);
        r_ext = CFG_W'(i_pos.row);
        xw    = i_pos.col - DIM_W'(1);
        yw    = i_pos.row - COORD_W'(1);
        interior = (i_cfg.frame_w >= DIM_W'(3)) && (i_cfg.frame_h >= CFG_W'(3))
                && (i_pos.col >= DIM_W'(2)) && (i_pos.col < i_cfg.frame_w)
                && (r_ext >= CFG_W'(2)) && (r_ext < i_cfg.frame_h);
        left   = (xw == DIM_W'(1));
        right  = (xw == w_m2);
        top    = (yw == COORD_W'(1));
        bottom = (CFG_W'(yw) == h_m2);
        x12    = xw[COORD_W-1:0];
        w12    = w_m1[COORD_W-1:0];
        h12    = h_m1[COORD_W-1:0];
    end

    // Site color from the pattern and the offset parities of the center
    assign site_idx = {~i_pos.row[0] ^ i_cfg.row_phase, ~i_pos.col[0] ^ i_cfg.column_phase};
    assign site     = SITE_TABLE[i_cfg.cfa_pattern][site_idx];

    // Truncating neighbor averages
    always_comb begin
        hv_sum = (PIX_W+2)'(i_win[3]) + (PIX_W+2)'(i_win[5])
               + (PIX_W+2)'(i_win[1]) + (PIX_W+2)'(i_win[7]);
        dg_sum = (PIX_W+2)'(i_win[0]) + (PIX_W+2)'(i_win[2])
               + (PIX_W+2)'(i_win[6]) + (PIX_W+2)'(i_win[8]);
        hz_sum = (PIX_W+1)'(i_win[3]) + (PIX_W+1)'(i_win[5]);
        vt_sum = (PIX_W+1)'(i_win[1]) + (PIX_W+1)'(i_win[7]);
        hv     = hv_sum[PIX_W+1:2];
        dg     = dg_sum[PIX_W+1:2];
        hz     = hz_sum[PIX_W:1];
        vt     = vt_sum[PIX_W:1];
    end

    // Pick the channels for the site color
    always_comb begin
        case (site)
            SITE_R: begin
                o_group.red = i_win[4]; o_group.green = hv; o_group.blue = dg;
            end
            SITE_G_RROW: begin
                o_group.red = hz; o_group.green = i_win[4]; o_group.blue = vt;
            end
            SITE_G_BROW: begin
                o_group.red = vt; o_group.green = i_win[4]; o_group.blue = hz;
            end
            default: begin
                o_group.red = dg; o_group.green = hv; o_group.blue = i_win[4];
            end
        endcase
    end

    // Rows and columns of the copies, in raster order
    always_comb begin
        o_group.rows[0] = top ? '0 : yw;
        o_group.rows[1] = top ? yw : h12;
        o_group.rows[2] = h12;
        o_group.row_cnt = 2'd1 + {1'b0, top} + {1'b0, bottom};
        o_group.cols[0] = left ? '0 : x12;
        o_group.cols[1] = left ? x12 : w12;
        o_group.cols[2] = w12;
        o_group.col_cnt = 2'd1 + {1'b0, left} + {1'b0, right};
        o_group.done    = (i_pos.col == w_m1) && (r_ext == h_m1);
    end

    assign o_push = i_pos.valid && interior;

endmodule

@@ hdl/bbd_emit.sv @@
// Result group queue and emitter that expands each group into output words.
module bbd_emit
    import bbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_group             i_group,
    input  logic               i_stall,
    output logic [CNT_W-1:0]   o_count,
    output logic               o_valid,
    output logic [PIX_W-1:0]   o_red,
    output logic [PIX_W-1:0]   o_green,
    output logic [PIX_W-1:0]   o_blue,
    output logic [COORD_W-1:0] o_pixel_column,
    output logic [COORD_W-1:0] o_pixel_row,
    output logic               o_last_of_run,
    output logic               o_frame_done
);

    t_group           r_queue [GRP_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_ri, n_ri;
    logic [1:0]       r_ci, n_ci;
    logic [1:0]       r_k, n_k;
    t_group           head;
    logic             row_last, col_last, last;
    logic             fire, pop;

    assign head     = r_queue[r_rd_ptr];
    assign o_valid  = (r_count != '0);
    assign row_last = (r_ri == head.row_cnt - 2'd1);
    assign col_last = (r_ci == head.col_cnt - 2'd1);
    assign last     = (r_k == 2'(RESULT_CAP - 1)) || (row_last && col_last);
    assign fire     = o_valid && !i_stall;
    assign pop      = fire && last;

    // Walk the copies of the head group
    always_comb begin
        n_ri = r_ri;
        n_ci = r_ci;
        n_k  = r_k;
        if (fire) begin
            if (last) begin
                n_ri = '0;
                n_ci = '0;
                n_k  = '0;
            end else begin
                if (col_last) begin
                    n_ci = '0;
                    n_ri = r_ri + 2'd1;
                end else begin
                    n_ci = r_ci + 2'd1;
                end
                n_k = r_k + 2'd1;
            end
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_ri     <= '0;
            r_ci     <= '0;
            r_k      <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
            r_ri    <= n_ri;
            r_ci    <= n_ci;
            r_k     <= n_k;
        end
    end

    // Store the incoming group
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_queue[r_wr_ptr] <= i_group;
        end
    end

    assign o_count        = r_count;
    assign o_red          = head.red;
    assign o_green        = head.green;
    assign o_blue         = head.blue;
    assign o_pixel_column = head.cols[r_ci];
    assign o_pixel_row    = head.rows[r_ri];
    assign o_last_of_run  = last;
    assign o_frame_done   = last && head.done;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == CNT_W'(GRP_DEPTH))))
        else $error("group pushed into full queue");

    a_group_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !last) |=> o_valid)
        else $error("group lost before its last word");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((r_ri < head.row_cnt) && (r_ci < head.col_cnt)))
        else $error("copy index beyond group");

endmodule
